// ----- rtl/svf_pkg.sv -----
// svf_pkg: widths, state codes, register indexes and saturation helpers
// for the state variable filter; used by rtl/state_variable_filter.sv
package svf_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 24;
    localparam int COEF_FRAC = 22;
    localparam int STATE_W   = 32;

    localparam int OPND_W = STATE_W + 1;
    localparam int PROD_W = STATE_W + COEF_W;
    localparam int RND_W  = PROD_W + 1 - COEF_FRAC;
    localparam int ACC_W  = RND_W + 2;
    localparam int IDX_W  = 2;

    typedef logic [2:0] fsm_state_t;
    typedef logic [IDX_W-1:0] reg_index_t;

    localparam fsm_state_t ST_IDLE   = 3'd0;
    localparam fsm_state_t ST_A1_I1  = 3'd1;
    localparam fsm_state_t ST_A2_V3  = 3'd2;
    localparam fsm_state_t ST_A2_I1  = 3'd3;
    localparam fsm_state_t ST_A3_V3  = 3'd4;
    localparam fsm_state_t ST_K_V1   = 3'd5;
    localparam fsm_state_t ST_FIN    = 3'd6;

    localparam reg_index_t REG_GAIN_A1 = 2'd0;
    localparam reg_index_t REG_GAIN_A2 = 2'd1;
    localparam reg_index_t REG_GAIN_A3 = 2'd2;
    localparam reg_index_t REG_DAMPING = 2'd3;

    localparam logic [COEF_W-1:0] GAIN_A1_RESET = COEF_W'(1) << COEF_FRAC;
    localparam logic [COEF_W-1:0] DAMPING_RESET = COEF_W'(1) << COEF_FRAC;

    localparam logic signed [ACC_W-1:0] STATE_HI = (ACC_W'(1) <<< (STATE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] STATE_LO = -STATE_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMP_HI   = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMP_LO   = -SMP_HI - ACC_W'(1);

    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [STATE_W-1:0]  state_val_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    function automatic state_val_t sat_state(input acc_t v);
        state_val_t r;
        if (v > STATE_HI)
            r = STATE_HI[STATE_W-1:0];
        else if (v < STATE_LO)
            r = STATE_LO[STATE_W-1:0];
        else
            r = v[STATE_W-1:0];
        return r;
    endfunction

    function automatic sample_t sat_sample(input acc_t v);
        sample_t r;
        if (v > SMP_HI)
            r = SMP_HI[SAMPLE_W-1:0];
        else if (v < SMP_LO)
            r = SMP_LO[SAMPLE_W-1:0];
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/state_variable_filter.sv -----
// state_variable_filter: trapezoidal state variable filter, one shared multiplier
// under a small sequencer; depends on rtl/svf_pkg.sv
//
// One sample item is taken while the sequencer is idle and the lowpass, bandpass
// and highpass result item is presented from the output register after the final
// step; no new sample is taken until the sequencer is back in idle. The pace is
// set by the single 32 x 24 unsigned multiplier, which is used five times in a row
// per sample (a1*s1, a2*v3, a2*s1, a3*v3, k*v1) with a final step for rounding the
// last product and updating the two integrator states. The result sits in an output
// register, so the next sample can be taken while it waits; a finished sample
// holds in its last step only if the previous result has still not been taken.
module state_variable_filter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  svf_pkg::reg_index_t                    wr_index,
    input  logic [svf_pkg::COEF_W-1:0]             wr_data,
    input  logic                                   sample_valid,
    output logic                                   sample_ready,
    input  logic signed [svf_pkg::SAMPLE_W-1:0]    sample_in,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic signed [svf_pkg::SAMPLE_W-1:0]    lowpass,
    output logic signed [svf_pkg::SAMPLE_W-1:0]    bandpass,
    output logic signed [svf_pkg::SAMPLE_W-1:0]    highpass
);

    logic [svf_pkg::COEF_W-1:0] gain_a1_reg, gain_a2_reg, gain_a3_reg, damping_reg;
    svf_pkg::fsm_state_t        state_reg, state_next;
    svf_pkg::state_val_t        integ_one_reg, integ_two_reg;
    svf_pkg::sample_t           x_reg;
    logic signed [svf_pkg::OPND_W-1:0] v3_reg;
    svf_pkg::state_val_t        v1_reg, v2_reg;
    svf_pkg::acc_t              acc_reg;
    logic [svf_pkg::PROD_W-1:0] prod_reg;
    logic                       neg_reg;
    logic                       result_valid_reg;
    svf_pkg::sample_t           lowpass_reg, bandpass_reg, highpass_reg;

    logic signed [svf_pkg::OPND_W-1:0] opnd;
    logic [svf_pkg::COEF_W-1:0]        coef;
    logic [svf_pkg::STATE_W-1:0]       mag;
    logic [svf_pkg::PROD_W:0]          rnd_sum;
    logic [svf_pkg::RND_W-1:0]         rnd;
    svf_pkg::acc_t                     term;
    svf_pkg::acc_t                     sum;
    svf_pkg::acc_t                     hp;
    logic                              take_in;
    logic                              slot_free;

    assign sample_ready = (state_reg == svf_pkg::ST_IDLE);
    assign take_in      = sample_valid && sample_ready;
    assign slot_free    = !result_valid_reg || result_ready;

    // operand select for the shared multiplier
    always_comb
    begin
        opnd = svf_pkg::OPND_W'(integ_one_reg);
        coef = gain_a1_reg;
        unique case (state_reg)
            svf_pkg::ST_A1_I1:
            begin
                opnd = svf_pkg::OPND_W'(integ_one_reg);
                coef = gain_a1_reg;
            end
            svf_pkg::ST_A2_V3:
            begin
                opnd = v3_reg;
                coef = gain_a2_reg;
            end
            svf_pkg::ST_A2_I1:
            begin
                opnd = svf_pkg::OPND_W'(integ_one_reg);
                coef = gain_a2_reg;
            end
            svf_pkg::ST_A3_V3:
            begin
                opnd = v3_reg;
                coef = gain_a3_reg;
            end
            svf_pkg::ST_K_V1:
            begin
                opnd = svf_pkg::OPND_W'(v1_reg);
                coef = damping_reg;
            end
            default:
            begin
                opnd = svf_pkg::OPND_W'(integ_one_reg);
                coef = gain_a1_reg;
            end
        endcase
    end

    assign mag = opnd[svf_pkg::OPND_W-1] ? svf_pkg::STATE_W'(-opnd)
                                         : svf_pkg::STATE_W'(opnd);

    // round half away from zero on the magnitude, then restore the sign
    assign rnd_sum = {1'b0, prod_reg}
                   + ((svf_pkg::PROD_W+1)'(1) << (svf_pkg::COEF_FRAC - 1));
    assign rnd     = svf_pkg::RND_W'(rnd_sum >> svf_pkg::COEF_FRAC);
    assign term    = neg_reg ? -svf_pkg::acc_t'({2'b00, rnd})
                             : svf_pkg::acc_t'({2'b00, rnd});
    assign sum     = acc_reg + term;
    assign hp      = svf_pkg::acc_t'(x_reg) - term - svf_pkg::acc_t'(v2_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            svf_pkg::ST_IDLE:  if (take_in) state_next = svf_pkg::ST_A1_I1;
            svf_pkg::ST_A1_I1: state_next = svf_pkg::ST_A2_V3;
            svf_pkg::ST_A2_V3: state_next = svf_pkg::ST_A2_I1;
            svf_pkg::ST_A2_I1: state_next = svf_pkg::ST_A3_V3;
            svf_pkg::ST_A3_V3: state_next = svf_pkg::ST_K_V1;
            svf_pkg::ST_K_V1:  state_next = svf_pkg::ST_FIN;
            svf_pkg::ST_FIN:   if (slot_free) state_next = svf_pkg::ST_IDLE;
            default:           state_next = svf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= svf_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
            integ_one_reg    <= '0;
            integ_two_reg    <= '0;
            gain_a1_reg      <= svf_pkg::GAIN_A1_RESET;
            gain_a2_reg      <= '0;
            gain_a3_reg      <= '0;
            damping_reg      <= svf_pkg::DAMPING_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    svf_pkg::REG_GAIN_A1: gain_a1_reg <= wr_data;
                    svf_pkg::REG_GAIN_A2: gain_a2_reg <= wr_data;
                    svf_pkg::REG_GAIN_A3: gain_a3_reg <= wr_data;
                    svf_pkg::REG_DAMPING: damping_reg <= wr_data;
                    default:              ;
                endcase
            end
            if (state_reg == svf_pkg::ST_FIN && slot_free)
            begin
                integ_one_reg    <= svf_pkg::sat_state(svf_pkg::acc_t'(v1_reg)
                                    + svf_pkg::acc_t'(v1_reg) - svf_pkg::acc_t'(integ_one_reg));
                integ_two_reg    <= svf_pkg::sat_state(svf_pkg::acc_t'(v2_reg)
                                    + svf_pkg::acc_t'(v2_reg) - svf_pkg::acc_t'(integ_two_reg));
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // the last product stays put while the final step waits
        if (state_reg != svf_pkg::ST_FIN)
        begin
            prod_reg <= svf_pkg::PROD_W'(mag) * svf_pkg::PROD_W'(coef);
            neg_reg  <= opnd[svf_pkg::OPND_W-1];
        end
        if (take_in)
        begin
            x_reg  <= sample_in;
            v3_reg <= svf_pkg::OPND_W'(sample_in) - svf_pkg::OPND_W'(integ_two_reg);
        end
        unique case (state_reg)
            svf_pkg::ST_A2_V3: acc_reg <= term;
            svf_pkg::ST_A2_I1: v1_reg  <= svf_pkg::sat_state(sum);
            svf_pkg::ST_A3_V3: acc_reg <= svf_pkg::acc_t'(integ_two_reg) + term;
            svf_pkg::ST_K_V1:  v2_reg  <= svf_pkg::sat_state(sum);
            svf_pkg::ST_FIN:
            begin
                if (slot_free)
                begin
                    lowpass_reg  <= svf_pkg::sat_sample(svf_pkg::acc_t'(v2_reg));
                    bandpass_reg <= svf_pkg::sat_sample(svf_pkg::acc_t'(v1_reg));
                    highpass_reg <= svf_pkg::sat_sample(hp);
                end
            end
            default: ;
        endcase
    end

    assign result_valid = result_valid_reg;
    assign lowpass      = lowpass_reg;
    assign bandpass     = bandpass_reg;
    assign highpass     = highpass_reg;

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> state_reg == svf_pkg::ST_A1_I1)
        else $error("sequencer did not start after sample item");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == svf_pkg::ST_FIN)
        else $error("result raised outside final step");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != svf_pkg::ST_FIN) |=> $stable(integ_one_reg) && $stable(integ_two_reg))
        else $error("integrator changed outside final step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |=> result_valid_reg && $stable(lowpass_reg)
            && $stable(bandpass_reg) && $stable(highpass_reg))
        else $error("pending result overwritten");

endmodule
